// ===== rtl/core/smi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_pkg
// Shared item types, opcodes, status codes and the instruction classes of the
// integer stack machine core.
// ----------------------------------------------------------------------------
package smi_pkg;

  typedef struct packed {
    logic [4:0]         action;
    logic signed [31:0] operand;
    logic [7:0]         arg_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        next_address;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               halted;
    logic [1:0]         status;
  } res_item_t;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_DIV   = 5'd3;
  localparam logic [4:0] OP_MOD   = 5'd4;
  localparam logic [4:0] OP_LT    = 5'd5;
  localparam logic [4:0] OP_LE    = 5'd6;
  localparam logic [4:0] OP_GT    = 5'd7;
  localparam logic [4:0] OP_GE    = 5'd8;
  localparam logic [4:0] OP_POP   = 5'd9;
  localparam logic [4:0] OP_PUSH  = 5'd10;
  localparam logic [4:0] OP_GET   = 5'd11;
  localparam logic [4:0] OP_SET   = 5'd12;
  localparam logic [4:0] OP_BR    = 5'd13;
  localparam logic [4:0] OP_BRZ   = 5'd14;
  localparam logic [4:0] OP_RET   = 5'd15;
  localparam logic [4:0] OP_RETV  = 5'd16;
  localparam logic [4:0] OP_CALL  = 5'd17;
  localparam logic [4:0] OP_EXIT  = 5'd18;
  localparam logic [4:0] OP_AND   = 5'd19;
  localparam logic [4:0] OP_OR    = 5'd20;
  localparam logic [4:0] OP_EQ    = 5'd21;
  localparam logic [4:0] OP_NE    = 5'd22;
  localparam logic [4:0] OP_PRINT = 5'd23;
  localparam logic [4:0] OP_NOT   = 5'd24;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [3:0] {
    CL_BIN, CL_DIVMOD, CL_POP, CL_PUSH, CL_GET, CL_SET, CL_BR, CL_BRZ,
    CL_RET, CL_CALL, CL_EXIT, CL_PRINT, CL_NOT, CL_NOP
  } class_e;

  typedef struct packed {
    class_e             cls;
    logic [4:0]         op;
    logic signed [31:0] operand;
    logic [7:0]         arg_count;
    logic [2:0]         nreads;
  } dec_t;

endpackage

// ===== rtl/core/smi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/smi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o
);

  logic        busy_q, done_q;
  logic [4:0]  step_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/core/smi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_front
// Accepts instruction items, classifies them and holds them in a two-entry
// queue for the execution side.
// ----------------------------------------------------------------------------
module smi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  smi_pkg::in_item_t item_i,
  output logic              dec_valid_o,
  output smi_pkg::dec_t     dec_o,
  input  logic              dec_pop_i
);
  import smi_pkg::*;

  function automatic dec_t classify(in_item_t it);
    dec_t d;
    d.op        = it.action;
    d.operand   = it.operand;
    d.arg_count = it.arg_count;
    d.nreads    = 3'd0;
    case (it.action)
      OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_LE, OP_GT, OP_GE,
      OP_AND, OP_OR, OP_EQ, OP_NE: begin
        d.cls = CL_BIN;
        d.nreads = 3'd2;
      end
      OP_DIV, OP_MOD: begin
        d.cls = CL_DIVMOD;
        d.nreads = 3'd2;
      end
      OP_POP:  d.cls = CL_POP;
      OP_PUSH: d.cls = CL_PUSH;
      OP_GET: begin
        d.cls = CL_GET;
        d.nreads = 3'd1;
      end
      OP_SET: begin
        d.cls = CL_SET;
        d.nreads = 3'd1;
      end
      OP_BR:   d.cls = CL_BR;
      OP_BRZ: begin
        d.cls = CL_BRZ;
        d.nreads = 3'd1;
      end
      OP_RET, OP_RETV: begin
        d.cls = CL_RET;
        d.nreads = 3'd4;
      end
      OP_CALL: d.cls = CL_CALL;
      OP_EXIT: d.cls = CL_EXIT;
      OP_PRINT: begin
        d.cls = CL_PRINT;
        d.nreads = 3'd1;
      end
      OP_NOT: begin
        d.cls = CL_NOT;
        d.nreads = 3'd1;
      end
      default: d.cls = CL_NOP;
    endcase
    return d;
  endfunction

  dec_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o      = cnt_q == 2'd2;
  assign dec_valid_o = cnt_q != 2'd0;
  assign dec_o       = q_q[rp_q];
  assign wr          = push_i & ~full_o;
  assign rd          = dec_pop_i & dec_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_q[wp_q] <= classify(item_i);
    end
  end

  queue_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("front queue count beyond two");

endmodule

// ===== rtl/core/smi_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_exec
// Execution side: operand stack and locals memories, frame and program
// counter, divider sequencing and the result register.
// ----------------------------------------------------------------------------
module smi_exec #(
  parameter int STACK_DEPTH    = 256,
  parameter int LOCALS_DEPTH   = 256,
  parameter int CODE_ADDR_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               dec_valid_i,
  input  smi_pkg::dec_t      dec_i,
  output logic               dec_pop_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               empty_o,
  input  logic               pop_i,
  output smi_pkg::res_item_t result_o
);
  import smi_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = $clog2(LOCALS_DEPTH);
  localparam int PCW = CODE_ADDR_BITS;
  localparam bit POW2 = (STACK_DEPTH & (STACK_DEPTH - 1)) == 0;
  localparam logic signed [33:0] SDEP = 34'(STACK_DEPTH);
  localparam logic signed [33:0] LDEP = 34'(LOCALS_DEPTH);
  // reciprocal of the stack depth for the frame base reduction
  localparam logic [63:0] FB_RECIP =
    ((64'd1 << (32 + SAW)) + 64'(STACK_DEPTH) - 64'd1) / 64'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_CALL1, S_CALL2, S_DONE
  } state_e;

  typedef enum logic [1:0] {DK_QUO, DK_REM, DK_FB} divkind_e;

  function automatic logic [31:0] alu(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    logic r;
    r = 1'b0;
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_LT:  r = $signed(a) <  $signed(b);
      OP_LE:  r = $signed(a) <= $signed(b);
      OP_GT:  r = $signed(a) >  $signed(b);
      OP_GE:  r = $signed(a) >= $signed(b);
      OP_AND: r = (a != 32'd0) && (b != 32'd0);
      OP_OR:  r = (a != 32'd0) || (b != 32'd0);
      OP_EQ:  r = a == b;
      default: r = a != b;
    endcase
    return {31'd0, r};
  endfunction

  state_e     state_q, state_d;
  dec_t       it_q, it_d;
  logic [1:0] rd_q, rd_d;
  logic [31:0] t_q [4];
  logic [31:0] t_d [4];
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [SAW-1:0] fb_q, fb_d;
  logic [PCW-1:0] pc_q, pc_d, pend_q, pend_d;
  logic       stop_q, stop_d;
  res_item_t  res_q, res_d, out_q, out_d;
  logic       out_vld_q, out_vld_d;
  divkind_e   dk_q, dk_d;
  logic       negq_q, negq_d, negr_q, negr_d;
  logic [31:0] fbq_q, fbq_d;

  logic           sram_we, lram_we;
  logic [SAW-1:0] sram_waddr, sram_raddr;
  logic [LAW-1:0] lram_waddr, lram_raddr;
  logic [31:0]    sram_wdata, lram_wdata, sram_rdata, lram_rdata;
  logic           dv_start, dv_done;
  logic [31:0]    dv_a, dv_b, dv_quo, dv_rem;

  logic [SCW-1:0] c_m1, c_m2;
  logic [SCW+1:0] c_ext;
  logic [SAW-1:0] f_m1, f_m2;
  logic [PCW-1:0] pc1, pc2, pc3, target;
  logic signed [33:0] idx_in, idx_it, nc;
  logic           in_stk, in_loc;
  logic [64:0]    fb_prod;
  logic [31:0]    fb_rem;

  logic           fin, f_pv, f_halt;
  logic [1:0]     f_st;
  logic [PCW-1:0] f_next;
  logic [31:0]    f_pval, rv, a_mag, b_mag;

  assign c_m1   = cnt_q - SCW'(1);
  assign c_m2   = cnt_q - SCW'(2);
  assign c_ext  = (SCW + 2)'(cnt_q);
  assign f_m1   = fb_q - SAW'(1);
  assign f_m2   = fb_q - SAW'(2);
  assign pc1    = pc_q + PCW'(1);
  assign pc2    = pc_q + PCW'(2);
  assign pc3    = pc_q + PCW'(3);
  assign target = it_q.operand[PCW-1:0];
  assign idx_in = $signed(34'(fb_q)) + 34'(dec_i.operand);
  assign idx_it = $signed(34'(fb_q)) + 34'(it_q.operand);
  assign in_stk = !idx_it[33] && (idx_it < SDEP);
  assign in_loc = !idx_it[33] && (idx_it < LDEP);
  assign nc     = $signed(34'(fb_q)) - 34'sd2 - 34'($signed(t_q[1]));
  assign rv     = (it_q.op == OP_RETV) ? t_q[0] : 32'd0;
  assign a_mag  = t_q[1][31] ? -t_q[1] : t_q[1];
  assign b_mag  = t_q[0][31] ? -t_q[0] : t_q[0];
  assign fb_prod = 65'(t_q[3]) * 65'(FB_RECIP[32:0]);
  assign fb_rem  = t_q[3] - fbq_q * 32'(STACK_DEPTH);
  assign lram_raddr = idx_in[LAW-1:0];

  always_comb begin
    state_d = state_q;  it_d = it_q;  rd_d = rd_q;  t_d = t_q;
    cnt_d = cnt_q;  fb_d = fb_q;  pc_d = pc_q;  stop_d = stop_q;
    res_d = res_q;  pend_d = pend_q;  dk_d = dk_q;
    negq_d = negq_q;  negr_d = negr_q;  fbq_d = fbq_q;
    out_d = out_q;
    out_vld_d = out_vld_q & ~pop_i;
    dec_pop_o = 1'b0;
    sram_we = 1'b0;  sram_waddr = '0;  sram_wdata = '0;  sram_raddr = '0;
    lram_we = 1'b0;  lram_waddr = '0;  lram_wdata = '0;
    dv_start = 1'b0;  dv_a = '0;  dv_b = '0;
    fin = 1'b0;  f_st = ST_OK;  f_next = pc1;  f_pv = 1'b0;  f_pval = '0;  f_halt = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (dec_valid_i) begin
          dec_pop_o = 1'b1;
          it_d = dec_i;
          rd_d = '0;
          if (stop_q) begin
            fin = 1'b1;
            f_next = pc_q;
            f_halt = 1'b1;
          end else begin
            sram_raddr = (dec_i.cls == CL_GET) ? idx_in[SAW-1:0] : c_m1[SAW-1:0];
            state_d = (dec_i.nreads == 3'd0) ? S_EXEC : S_READ;
          end
        end
      end
      S_READ: begin
        t_d[rd_q] = (it_q.cls == CL_GET && !it_q.operand[31]) ? lram_rdata : sram_rdata;
        if (3'(rd_q) + 3'd1 == it_q.nreads) begin
          state_d = S_EXEC;
        end else begin
          rd_d = rd_q + 2'd1;
        end
        if (it_q.cls == CL_RET) begin
          case (rd_q)
            2'd0:    sram_raddr = f_m2;
            2'd1:    sram_raddr = fb_q;
            default: sram_raddr = f_m1;
          endcase
        end else begin
          sram_raddr = c_m2[SAW-1:0];
        end
      end
      S_EXEC: begin
        case (it_q.cls)
          CL_BIN: begin
            fin = 1'b1;
            if (cnt_q < SCW'(2)) begin
              f_st = ST_UNDER;
            end else begin
              sram_we = 1'b1;
              sram_waddr = c_m2[SAW-1:0];
              sram_wdata = alu(it_q.op, t_q[1], t_q[0]);
              cnt_d = c_m1;
            end
          end
          CL_DIVMOD: begin
            if (cnt_q < SCW'(2)) begin
              fin = 1'b1;
              f_st = ST_UNDER;
            end else if (t_q[0] == 32'd0) begin
              fin = 1'b1;
              f_st = ST_DIVZ;
            end else begin
              dv_start = 1'b1;
              dv_a = a_mag;
              dv_b = b_mag;
              negq_d = t_q[1][31] ^ t_q[0][31];
              negr_d = t_q[1][31];
              dk_d = (it_q.op == OP_DIV) ? DK_QUO : DK_REM;
              state_d = S_DIV;
            end
          end
          CL_POP: begin
            fin = 1'b1;
            if (cnt_q == '0) f_st = ST_UNDER;
            else cnt_d = c_m1;
          end
          CL_PUSH, CL_GET: begin
            fin = 1'b1;
            f_next = pc2;
            if (cnt_q == SCW'(STACK_DEPTH)) begin
              f_st = ST_OVER;
            end else begin
              sram_we = 1'b1;
              sram_waddr = cnt_q[SAW-1:0];
              if (it_q.cls == CL_PUSH) begin
                sram_wdata = it_q.operand;
              end else if (it_q.operand[31]) begin
                sram_wdata = in_stk ? t_q[0] : 32'd0;
              end else begin
                sram_wdata = in_loc ? t_q[0] : 32'd0;
              end
              cnt_d = cnt_q + SCW'(1);
            end
          end
          CL_SET: begin
            fin = 1'b1;
            f_next = pc2;
            if (cnt_q == '0) begin
              f_st = ST_UNDER;
            end else begin
              cnt_d = c_m1;
              sram_we = it_q.operand[31] && in_stk;
              sram_waddr = idx_it[SAW-1:0];
              sram_wdata = t_q[0];
              lram_we = !it_q.operand[31] && in_loc;
              lram_waddr = idx_it[LAW-1:0];
              lram_wdata = t_q[0];
            end
          end
          CL_BR: begin
            fin = 1'b1;
            f_next = target;
          end
          CL_BRZ: begin
            fin = 1'b1;
            f_next = pc2;
            if (cnt_q == '0) begin
              f_st = ST_UNDER;
            end else begin
              cnt_d = c_m1;
              if (t_q[0] == 32'd0) f_next = target;
            end
          end
          CL_RET: begin
            if (cnt_q == '0 || fb_q < SAW'(2) || nc[33]) begin
              fin = 1'b1;
              f_st = ST_UNDER;
            end else if (nc >= SDEP) begin
              fin = 1'b1;
              f_st = ST_OVER;
            end else begin
              sram_we = 1'b1;
              sram_waddr = nc[SAW-1:0];
              sram_wdata = rv;
              cnt_d = SCW'(nc) + SCW'(1);
              if (POW2) begin
                fin = 1'b1;
                fb_d = t_q[3][SAW-1:0];
                f_next = t_q[2][PCW-1:0];
              end else begin
                pend_d = t_q[2][PCW-1:0];
                dk_d = DK_FB;
                fbq_d = 32'(fb_prod >> (32 + SAW));
                state_d = S_DIV;
              end
            end
          end
          CL_CALL: begin
            if (c_ext + (SCW + 2)'(3) > (SCW + 2)'(STACK_DEPTH)) begin
              fin = 1'b1;
              f_st = ST_OVER;
            end else begin
              sram_we = 1'b1;
              sram_waddr = cnt_q[SAW-1:0];
              sram_wdata = 32'(it_q.arg_count);
              state_d = S_CALL1;
            end
          end
          CL_EXIT: begin
            fin = 1'b1;
            f_halt = 1'b1;
          end
          CL_PRINT: begin
            fin = 1'b1;
            if (cnt_q == '0) begin
              f_st = ST_UNDER;
            end else begin
              cnt_d = c_m1;
              f_pv = 1'b1;
              f_pval = t_q[0];
            end
          end
          CL_NOT: begin
            fin = 1'b1;
            if (cnt_q == '0) begin
              f_st = ST_UNDER;
            end else begin
              sram_we = 1'b1;
              sram_waddr = c_m1[SAW-1:0];
              sram_wdata = {31'd0, t_q[0] == 32'd0};
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_DIV: begin
        if (dk_q == DK_FB) begin
          fin = 1'b1;
          fb_d = fb_rem[SAW-1:0];
          f_next = pend_q;
        end else if (dv_done) begin
          fin = 1'b1;
          sram_we = 1'b1;
          sram_waddr = c_m2[SAW-1:0];
          cnt_d = c_m1;
          if (dk_q == DK_QUO) begin
            sram_wdata = negq_q ? -dv_quo : dv_quo;
          end else begin
            sram_wdata = negr_q ? -dv_rem : dv_rem;
          end
        end
      end
      S_CALL1: begin
        sram_we = 1'b1;
        sram_waddr = SAW'(c_ext + (SCW + 2)'(1));
        sram_wdata = 32'(fb_q);
        state_d = S_CALL2;
      end
      S_CALL2: begin
        sram_we = 1'b1;
        sram_waddr = SAW'(c_ext + (SCW + 2)'(2));
        sram_wdata = 32'(pc3);
        cnt_d = SCW'(c_ext + (SCW + 2)'(3));
        fb_d = SAW'(c_ext + (SCW + 2)'(2));
        fin = 1'b1;
        f_next = target;
      end
      S_DONE: begin
        if (!out_vld_q || pop_i) begin
          out_d = res_q;
          out_vld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      if (f_st != ST_OK) begin
        stop_d = 1'b1;
        res_d.next_address = 16'(pc_q);
      end else begin
        pc_d = f_next;
        stop_d = stop_q | f_halt;
        res_d.next_address = 16'(f_next);
      end
      res_d.print_valid = f_pv;
      res_d.print_value = f_pval;
      res_d.halted = stop_d;
      res_d.status = f_st;
      state_d = S_DONE;
    end

    if (cfg_we_i) pc_d = PCW'(cfg_wdata_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_q      <= '0;
      cnt_q     <= '0;
      fb_q      <= '0;
      pc_q      <= '0;
      stop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      cnt_q     <= cnt_d;
      fb_q      <= fb_d;
      pc_q      <= pc_d;
      stop_q    <= stop_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    t_q    <= t_d;
    res_q  <= res_d;
    out_q  <= out_d;
    pend_q <= pend_d;
    dk_q   <= dk_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
    fbq_q  <= fbq_d;
  end

  assign empty_o  = ~out_vld_q;
  assign result_o = out_q;

  smi_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (sram_we),
    .waddr_i (sram_waddr),
    .wdata_i (sram_wdata),
    .raddr_i (sram_raddr),
    .rdata_o (sram_rdata)
  );

  smi_ram #(.WIDTH(32), .DEPTH(LOCALS_DEPTH)) u_locals_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .waddr_i (lram_waddr),
    .wdata_i (lram_wdata),
    .raddr_i (lram_raddr),
    .rdata_o (lram_rdata)
  );

  smi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dv_start),
    .dividend_i  (dv_a),
    .divisor_i   (dv_b),
    .done_o      (dv_done),
    .quotient_o  (dv_quo),
    .remainder_o (dv_rem)
  );

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SCW'(STACK_DEPTH)) else $error("stack count beyond depth");

  stop_sticky_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q) else $error("stopped machine restarted");

  halted_rep_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && stop_q) |-> res_q.halted)
    else $error("stopped machine reports not halted");

endmodule

// ===== rtl/core/stack_machine_integer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_integer_core
// Integer stack machine: one decoded instruction per item, one result item
// per instruction.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// items     in         push / full           in_item_i  (smi_pkg::in_item_t)
// results   out        empty / pop           result_o   (smi_pkg::res_item_t)
// config    in         cfg_we_i (no wait)    cfg_wdata_i, entry address
//
// an item makes one stack read per operand it needs (up to 4, for returns)
// a call writes the saved frame base and return address in S_CALL1 and S_CALL2
// div and mod wait in S_DIV for the bit-serial divider; a return also passes
// through S_DIV for the frame base reduction when the stack depth is not a power of two
// reset needs no clearing pass; stack and locals are undefined until written
// a two-entry queue takes items while the result register waits for pop
// ----------------------------------------------------------------------------
module stack_machine_integer_core #(
  parameter int STACK_DEPTH    = 256,
  parameter int LOCALS_DEPTH   = 256,
  parameter int CODE_ADDR_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  smi_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output smi_pkg::res_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import smi_pkg::*;

  logic dec_valid, dec_pop;
  dec_t dec;

  smi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .dec_valid_o (dec_valid),
    .dec_o       (dec),
    .dec_pop_i   (dec_pop)
  );

  smi_exec #(
    .STACK_DEPTH    (STACK_DEPTH),
    .LOCALS_DEPTH   (LOCALS_DEPTH),
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (dec_valid),
    .dec_i       (dec),
    .dec_pop_o   (dec_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule
